// File: rtl/alr_pkg.sv
package alr_pkg;

  localparam int CoordW     = 17;
  localparam int PixW       = 14;
  localparam int AlphaW     = 8;
  localparam int CfgW       = 12;
  localparam int SlopeW     = 18;
  localparam int InterceptW = 34;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ALPHA  = 2'd2;

  // One queued item, already classified as load or step.
  typedef struct packed {
    logic                     is_load;
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
  } item_t;

  // One column pair as it leaves the block.
  typedef struct packed {
    logic [PixW-1:0]   pix_x;
    logic [PixW-1:0]   pix_y;
    logic [AlphaW-1:0] alpha_near;
    logic [AlphaW-1:0] alpha_far;
    logic              steep;
    logic              valid_res;
    logic              last;
  } res_t;

endpackage

// File: rtl/alr_front.sv
module alr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           opcode_i,
  input  logic [16:0]    start_x_i,
  input  logic [16:0]    start_y_i,
  input  logic [16:0]    end_x_i,
  input  logic [16:0]    end_y_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output alr_pkg::item_t item_o
);
  import alr_pkg::*;

  item_t       mem_q [2];
  item_t       item_in;
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  // Classify the incoming item; coordinates only matter for a load.
  always_comb begin
    item_in.is_load = (opcode_i == OP_LOAD);
    item_in.x0      = start_x_i;
    item_in.y0      = start_y_i;
    item_in.x1      = end_x_i;
    item_in.y1      = end_y_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// File: rtl/alr_back.sv
module alr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  alr_pkg::item_t item_i,
  output logic           ready_o,
  input  logic [11:0]    width_i,
  input  logic [11:0]    height_i,
  input  logic [7:0]     alpha_i,
  output logic           done_o,
  output alr_pkg::res_t  res_o
);
  import alr_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_PREP = 4'b0010,
    B_DIV  = 4'b0100,
    B_FIN  = 4'b1000
  } bstate_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_e;

  bstate_e bstate_q, bstate_d;
  phase_e  phase_q, phase_d;
  logic    steep_q, steep_d;
  logic signed [PixW-1:0]       column_q, column_d, end_col_q, end_col_d;
  logic signed [PixW-1:0]       row1_q, row1_d, row2_q, row2_d;
  logic [15:0]                  al1_q, al1_d, al2_q, al2_d;
  logic signed [InterceptW-1:0] intercept_q, intercept_d;
  logic signed [SlopeW-1:0]     slope_q, slope_d;
  logic signed [CoordW-1:0]     sx0_q, sx0_d, sy0_q, sy0_d, sx1_q, sx1_d, sy1_q, sy1_d;
  logic [17:0]                  dx_q, dx_d, ady_q, ady_d;
  logic                         neg_q, neg_d, zero_dx_q, zero_dx_d;
  logic [8:0]                   c1n_q, c1n_d, c1f_q, c1f_d, c2n_q, c2n_d, c2f_q, c2f_d;
  logic [17:0]                  rem_q, rem_d;
  logic                         q16_q, q16_d;
  logic [15:0]                  quo_q, quo_d;
  logic [3:0]                   cnt_q, cnt_d;
  res_t                         res_q, res_d;
  logic                         done_q, done_d;

  // Load sorting signals.
  logic signed [17:0] x0e, y0e, x1e, y1e, wr, hb, dxs, dys, a0, b0, a1, b1, dmaj, dmin;
  logic [17:0]        adx, ady;
  logic               cull, steep_c, swap;
  // End coverage and divider signals.
  logic [4:0]  gap1, gap2, yf1, yf2;
  logic [18:0] rem_sh;
  logic        ge;
  logic [16:0] mag;
  logic signed [SlopeW-1:0] slope_c;
  // Column step signals.
  logic        last_c;
  logic [16:0] fr_inv;
  logic [24:0] an_p, af_p;
  logic signed [PixW-1:0] major, minor;
  logic [15:0] alphas;

  assign ready_o = (bstate_q == B_IDLE);
  assign done_o  = done_q;
  assign res_o   = res_q;

  always_comb begin
    x0e = $signed({item_i.x0[16], item_i.x0});
    y0e = $signed({item_i.y0[16], item_i.y0});
    x1e = $signed({item_i.x1[16], item_i.x1});
    y1e = $signed({item_i.y1[16], item_i.y1});
    wr  = $signed({2'b00, width_i, 4'b0000});
    hb  = $signed({2'b00, height_i, 4'b0000});
    cull = (x0e < 0 && x1e < 0) || (x0e > wr && x1e > wr) ||
           (y0e < 0 && y1e < 0) || (y0e > hb && y1e > hb);
    dxs = x1e - x0e;
    dys = y1e - y0e;
    adx = dxs[17] ? 18'(-dxs) : 18'(dxs);
    ady = dys[17] ? 18'(-dys) : 18'(dys);
    steep_c = ady > adx;
    a0 = steep_c ? y0e : x0e;
    b0 = steep_c ? x0e : y0e;
    a1 = steep_c ? y1e : x1e;
    b1 = steep_c ? x1e : y1e;
    swap = a0 > a1;
    dmaj = swap ? a0 - a1 : a1 - a0;
    dmin = swap ? b0 - b1 : b1 - b0;

    gap1 = 5'd16 - {1'b0, sx0_q[3:0] + 4'd8};
    gap2 = {1'b0, sx1_q[3:0] + 4'd8};
    yf1  = {1'b0, sy0_q[3:0]};
    yf2  = {1'b0, sy1_q[3:0]};

    rem_sh = {rem_q, 1'b0};
    ge     = rem_sh >= {1'b0, dx_q};
    mag    = {q16_q, quo_q};
    slope_c = zero_dx_q ? SlopeW'(18'sd65536) :
              (neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));

    last_c = !(($signed({column_q[13], column_q}) + 15'sd1) <
               $signed({end_col_q[13], end_col_q}));
    fr_inv = 17'h10000 - {1'b0, intercept_q[15:0]};
    an_p   = 25'(alpha_i * fr_inv);
    af_p   = 25'(alpha_i * intercept_q[15:0]);
  end

  always_comb begin
    bstate_d = bstate_q;   phase_d = phase_q;   steep_d = steep_q;
    column_d = column_q;   end_col_d = end_col_q;
    row1_d = row1_q;       row2_d = row2_q;      al1_d = al1_q;   al2_d = al2_q;
    intercept_d = intercept_q;  slope_d = slope_q;
    sx0_d = sx0_q;  sy0_d = sy0_q;  sx1_d = sx1_q;  sy1_d = sy1_q;
    dx_d = dx_q;    ady_d = ady_q;  neg_d = neg_q;  zero_dx_d = zero_dx_q;
    c1n_d = c1n_q;  c1f_d = c1f_q;  c2n_d = c2n_q;  c2f_d = c2f_q;
    rem_d = rem_q;  q16_d = q16_q;  quo_d = quo_q;  cnt_d = cnt_q;
    res_d = res_q;  done_d = 1'b0;
    major = '0;     minor = '0;     alphas = '0;

    case (bstate_q)
      B_IDLE: begin
        if (valid_i && item_i.is_load) begin
          if (cull) begin
            phase_d = PH_IDLE;
          end else begin
            steep_d   = steep_c;
            sx0_d     = CoordW'(swap ? a1 : a0);
            sy0_d     = CoordW'(swap ? b1 : b0);
            sx1_d     = CoordW'(swap ? a0 : a1);
            sy1_d     = CoordW'(swap ? b0 : b1);
            dx_d      = 18'(dmaj);
            ady_d     = dmin[17] ? 18'(-dmin) : 18'(dmin);
            neg_d     = dmin[17];
            zero_dx_d = (dmaj == 0);
            bstate_d  = B_PREP;
          end
        end else if (valid_i) begin
          done_d = 1'b1;
          case (phase_q)
            PH_FIRST: begin
              major = column_q;  minor = row1_q;  alphas = al1_q;
              res_d = '{pix_x: steep_q ? minor : major, pix_y: steep_q ? major : minor,
                        alpha_near: alphas[15:8], alpha_far: alphas[7:0],
                        steep: steep_q, valid_res: 1'b1, last: 1'b0};
              phase_d = PH_SECOND;
            end
            PH_SECOND: begin
              major = end_col_q;  minor = row2_q;  alphas = al2_q;
              res_d = '{pix_x: steep_q ? minor : major, pix_y: steep_q ? major : minor,
                        alpha_near: alphas[15:8], alpha_far: alphas[7:0],
                        steep: steep_q, valid_res: 1'b1, last: last_c};
              if (last_c) begin
                phase_d = PH_IDLE;
              end else begin
                column_d = column_q + 14'sd1;
                phase_d  = PH_BODY;
              end
            end
            PH_BODY: begin
              major  = column_q;
              minor  = intercept_q[29:16];
              alphas = {an_p[23:16], af_p[23:16]};
              res_d = '{pix_x: steep_q ? minor : major, pix_y: steep_q ? major : minor,
                        alpha_near: alphas[15:8], alpha_far: alphas[7:0],
                        steep: steep_q, valid_res: 1'b1, last: last_c};
              intercept_d = intercept_q + InterceptW'(slope_q);
              column_d    = column_q + 14'sd1;
              if (last_c) phase_d = PH_IDLE;
            end
            default: begin
              res_d = '{pix_x: '0, pix_y: '0, alpha_near: '0, alpha_far: '0,
                        steep: 1'b0, valid_res: 1'b0, last: 1'b1};
            end
          endcase
        end
      end
      B_PREP: begin
        c1n_d     = 9'((5'd16 - yf1) * gap1);
        c1f_d     = 9'(yf1 * gap1);
        c2n_d     = 9'((5'd16 - yf2) * gap2);
        c2f_d     = 9'(yf2 * gap2);
        row1_d    = PixW'(sy0_q >>> 4);
        row2_d    = PixW'(sy1_q >>> 4);
        column_d  = PixW'(sx0_q >>> 4);
        end_col_d = PixW'(sx1_q >>> 4);
        // The minor extent never exceeds the major one, so the top quotient
        // bit is set only when they are equal.
        q16_d    = (ady_q >= dx_q);
        rem_d    = (ady_q >= dx_q) ? ady_q - dx_q : ady_q;
        cnt_d    = 4'd0;
        bstate_d = B_DIV;
      end
      B_DIV: begin
        rem_d = ge ? 18'(rem_sh - {1'b0, dx_q}) : 18'(rem_sh);
        quo_d = {quo_q[14:0], ge};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) bstate_d = B_FIN;
      end
      B_FIN: begin
        slope_d     = slope_c;
        intercept_d = $signed({{5{sy0_q[16]}}, sy0_q, 12'b0}) + InterceptW'(slope_c);
        al1_d = {8'(17'(alpha_i * c1n_q) >> 8), 8'(17'(alpha_i * c1f_q) >> 8)};
        al2_d = {8'(17'(alpha_i * c2n_q) >> 8), 8'(17'(alpha_i * c2f_q) >> 8)};
        phase_d  = PH_FIRST;
        bstate_d = B_IDLE;
      end
      default: bstate_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bstate_q <= B_IDLE;
      phase_q  <= PH_IDLE;
      steep_q  <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= 4'd0;
    end else begin
      bstate_q <= bstate_d;
      phase_q  <= phase_d;
      steep_q  <= steep_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    column_q <= column_d;  end_col_q <= end_col_d;
    row1_q <= row1_d;      row2_q <= row2_d;
    al1_q <= al1_d;        al2_q <= al2_d;
    intercept_q <= intercept_d;  slope_q <= slope_d;
    sx0_q <= sx0_d;  sy0_q <= sy0_d;  sx1_q <= sx1_d;  sy1_q <= sy1_d;
    dx_q <= dx_d;    ady_q <= ady_d;  neg_q <= neg_d;  zero_dx_q <= zero_dx_d;
    c1n_q <= c1n_d;  c1f_q <= c1f_d;  c2n_q <= c2n_d;  c2f_q <= c2f_d;
    rem_q <= rem_d;  q16_q <= q16_d;  quo_q <= quo_d;
    res_q <= res_d;
  end

endmodule

// File: rtl/antialiased_line_rasterizer_top.sv
// Step item: queued, then its result is registered and strobed on done_o; one step per cycle
// sustained while no load is in setup. Load item: no result; the back end sets up through prep,
// one-bit-per-cycle slope division and finish. Steps queued behind a load wait for it to finish.
// busy_o rises only when the two-entry item queue is full. Results cannot be stalled.
// Reset (asynchronous, active low) empties the queue, idles the line engine and loads
// window 800 x 600 and draw alpha 255.
module antialiased_line_rasterizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [16:0] start_x_i,
  input  logic [16:0] start_y_i,
  input  logic [16:0] end_x_i,
  input  logic [16:0] end_y_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  output logic        done_o,
  output logic [13:0] pix_x_o,
  output logic [13:0] pix_y_o,
  output logic [7:0]  alpha_near_o,
  output logic [7:0]  alpha_far_o,
  output logic        steep_o,
  output logic        valid_res_o,
  output logic        last_o
);
  import alr_pkg::*;

  logic [CfgW-1:0]   width_q, height_q;
  logic [AlphaW-1:0] alpha_q;
  logic              push, full, q_valid, back_ready, pop;
  item_t             q_item;
  res_t              res;

  // Writes are registered; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd800;
      height_q <= 12'd600;
      alpha_q  <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_ALPHA:  alpha_q  <= cfg_data_i[7:0];
        default:    ;
      endcase
    end
  end

  // An item is taken whenever the queue has room, so the front end keeps
  // accepting while the back end grinds through a load.
  assign busy_o = full;
  assign push   = start_i && !full;
  assign pop    = q_valid && back_ready;

  alr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .opcode_i  (opcode_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .full_o    (full),
    .valid_o   (q_valid),
    .pop_i     (pop),
    .item_o    (q_item)
  );

  // The back end sorts and culls a load, computes end coverage, divides for
  // the slope, then emits one column pair per step item.
  alr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .item_i   (q_item),
    .ready_o  (back_ready),
    .width_i  (width_q),
    .height_i (height_q),
    .alpha_i  (alpha_q),
    .done_o   (done_o),
    .res_o    (res)
  );

  assign pix_x_o      = res.pix_x;
  assign pix_y_o      = res.pix_y;
  assign alpha_near_o = res.alpha_near;
  assign alpha_far_o  = res.alpha_far;
  assign steep_o      = res.steep;
  assign valid_res_o  = res.valid_res;
  assign last_o       = res.last;

endmodule

// File: rtl/alr_checker.sv
module alr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [13:0] pix_x_o,
  input logic [13:0] pix_y_o,
  input logic [7:0]  alpha_near_o,
  input logic [7:0]  alpha_far_o,
  input logic        steep_o,
  input logic        valid_res_o,
  input logic        last_o
);

  // A pair never carries more coverage than one full pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && valid_res_o |-> ({1'b0, alpha_near_o} + {1'b0, alpha_far_o}) <= 9'd255)
    else $error("pair alphas exceed full coverage");

  // A step with no line pending reports an empty final pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !valid_res_o |-> last_o && !steep_o && pix_x_o == 14'd0 &&
                               pix_y_o == 14'd0 && alpha_near_o == 8'd0 &&
                               alpha_far_o == 8'd0)
    else $error("idle result not empty");

  // Leaving reset, nothing is queued and nothing is reported.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !done_o && !busy_o)
    else $error("activity right after reset");

  // The queue cannot fill without an item being offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("queue filled without an item");

endmodule

bind antialiased_line_rasterizer_top alr_checker u_alr_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import alr_pkg::*;

  // Phases of the line engine as tracked by the predictor.
  typedef enum int {LnIdle, LnFirst, LnSecond, LnBody} line_phase_e;

  // Holds predicted column pairs in issue order and checks the block's output against them.
  class pair_scoreboard;
    res_t pending_pairs[$];
    int   errors;

    function void note(res_t r);
      pending_pairs.push_back(r);
    endfunction

    function void check(res_t got);
      res_t want;
      if (pending_pairs.size() == 0) begin
        $error("column pair with none expected: %p", got);
        errors++;
        return;
      end
      want = pending_pairs.pop_front();
      if (got.pix_x !== want.pix_x) begin
        $error("pix_x expected %0h actual %0h", want.pix_x, got.pix_x); errors++;
      end
      if (got.pix_y !== want.pix_y) begin
        $error("pix_y expected %0h actual %0h", want.pix_y, got.pix_y); errors++;
      end
      if (got.alpha_near !== want.alpha_near) begin
        $error("alpha_near expected %0d actual %0d", want.alpha_near, got.alpha_near);
        errors++;
      end
      if (got.alpha_far !== want.alpha_far) begin
        $error("alpha_far expected %0d actual %0d", want.alpha_far, got.alpha_far); errors++;
      end
      if (got.steep !== want.steep) begin
        $error("steep expected %0b actual %0b", want.steep, got.steep); errors++;
      end
      if (got.valid_res !== want.valid_res) begin
        $error("valid_res expected %0b actual %0b", want.valid_res, got.valid_res); errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0b actual %0b", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni, start_i, busy_o, opcode_i;
  logic [16:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [11:0] cfg_data_i;
  logic        done_o;
  logic [13:0] pix_x_o, pix_y_o;
  logic [7:0]  alpha_near_o, alpha_far_o;
  logic        steep_o, valid_res_o, last_o;

  antialiased_line_rasterizer_top DUT (.*);

  pair_scoreboard sb;
  bit             allow_gaps;
  int             sent;

  // Predictor copy of the configuration and the line engine state.
  longint      win_w, win_h, draw_a;
  line_phase_e ln_phase;
  bit          ln_steep;
  longint      ln_col, ln_end_col, ln_icpt, ln_slope, row_first, row_second;
  logic [15:0] alphas_first, alphas_second;

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // The receiver cannot stall, so every strobed cycle is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1 && sb != null)
      sb.check('{pix_x_o, pix_y_o, alpha_near_o, alpha_far_o, steep_o, valid_res_o, last_o});
  end

  // End coverage: near pixel gets (1 - frac(y)) * gap, far pixel frac(y) * gap, floored.
  function automatic logic [15:0] cover_end(longint y, longint gap);
    longint yf, an, af;
    yf = y & 15;
    an = (draw_a * (16 - yf) * gap) >> 8;
    af = (draw_a * yf * gap) >> 8;
    return {an[7:0], af[7:0]};
  endfunction

  function automatic res_t make_pair(longint major, longint minor, logic [15:0] al,
                                     bit is_last);
    res_t r;
    longint px, py;
    px = ln_steep ? minor : major;
    py = ln_steep ? major : minor;
    r.pix_x = px[13:0];
    r.pix_y = py[13:0];
    r.alpha_near = al[15:8];
    r.alpha_far = al[7:0];
    r.steep = ln_steep;
    r.valid_res = 1'b1;
    r.last = is_last;
    return r;
  endfunction

  // Sets up a new line, or idles the engine when both ends lie past one window edge.
  function automatic void setup_line(logic [16:0] sx, logic [16:0] sy,
                                     logic [16:0] ex, logic [16:0] ey);
    longint x0, y0, x1, y1, t, dx, dy, mag, wr, hb;
    x0 = longint'($signed(sx)); y0 = longint'($signed(sy));
    x1 = longint'($signed(ex)); y1 = longint'($signed(ey));
    wr = win_w << 4;
    hb = win_h << 4;
    if ((x0 < 0 && x1 < 0) || (x0 > wr && x1 > wr) ||
        (y0 < 0 && y1 < 0) || (y0 > hb && y1 > hb)) begin
      ln_phase = LnIdle;
      return;
    end
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    ln_steep = dy > dx;
    if (ln_steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    // A line of zero length along the major axis gets a slope of exactly one.
    if (dx == 0) begin
      ln_slope = 64'sd1 << 16;
    end else begin
      mag = ((dy < 0 ? -dy : dy) << 16) / dx;
      ln_slope = dy < 0 ? -mag : mag;
    end
    row_first = y0 >>> 4;
    alphas_first = cover_end(y0, 16 - ((x0 + 8) & 15));
    ln_col = x0 >>> 4;
    row_second = y1 >>> 4;
    alphas_second = cover_end(y1, (x1 + 8) & 15);
    ln_end_col = x1 >>> 4;
    ln_icpt = (y0 <<< 12) + ln_slope;
    ln_phase = LnFirst;
  endfunction

  // Works out the column pair that one step item returns and advances the engine.
  function automatic res_t step_line();
    res_t r;
    longint fr, an, af;
    bit is_last;
    r = '0;
    case (ln_phase)
      LnFirst: begin
        r = make_pair(ln_col, row_first, alphas_first, 1'b0);
        ln_phase = LnSecond;
      end
      LnSecond: begin
        is_last = !(ln_col + 1 < ln_end_col);
        r = make_pair(ln_end_col, row_second, alphas_second, is_last);
        if (is_last) ln_phase = LnIdle;
        else begin
          ln_col++;
          ln_phase = LnBody;
        end
      end
      LnBody: begin
        fr = ln_icpt & 64'hFFFF;
        an = (draw_a * (65536 - fr)) >> 16;
        af = (draw_a * fr) >> 16;
        is_last = !(ln_col + 1 < ln_end_col);
        r = make_pair(ln_col, ln_icpt >>> 16, {an[7:0], af[7:0]}, is_last);
        ln_icpt += ln_slope;
        ln_col++;
        if (is_last) ln_phase = LnIdle;
      end
      // A step with no line pending returns an empty pair flagged last.
      default: r.last = 1'b1;
    endcase
    return r;
  endfunction

  // Presents one item, holds it until the block takes it, then predicts its effect.
  task automatic send_item(logic op, logic [16:0] sx, logic [16:0] sy,
                           logic [16:0] ex, logic [16:0] ey);
    int gap;
    start_i <= 1'b1;
    opcode_i <= op;
    start_x_i <= sx; start_y_i <= sy; end_x_i <= ex; end_y_i <= ey;
    do @(posedge clk_i); while (busy_o);
    sent++;
    if (op == OP_LOAD) setup_line(sx, sy, ex, ey);
    else sb.note(step_line());
    gap = (allow_gaps && $urandom_range(0, 9) < 3) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_step();
    send_item(OP_STEP, 17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
  endtask

  // Stops sending and lets every expected pair arrive; a trailing load may still be in setup,
  // so the block is given a load's latency on top before anything else happens.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_pairs.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Writes all three registers back to back; the upper data bits of draw_alpha are don't-care.
  task automatic write_config(logic [11:0] w, logic [11:0] h, logic [7:0] a);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WIDTH; cfg_data_i <= w;
    @(posedge clk_i);
    win_w = w;
    cfg_idx_i <= CFG_HEIGHT; cfg_data_i <= h;
    @(posedge clk_i);
    win_h = h;
    cfg_idx_i <= CFG_ALPHA; cfg_data_i <= {4'($urandom), a};
    @(posedge clk_i);
    draw_a = a;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Loads a short line near the window and steps it through to its last column, sometimes
  // cutting it off with the next load or running a few idle steps past its end.
  task automatic draw_random_line();
    longint bx, by, lx, ly;
    int n, cap;
    bx = $urandom_range(0, (win_w + 8) * 16) - 64;
    by = $urandom_range(0, (win_h + 8) * 16) - 64;
    lx = longint'($urandom_range(0, 600)) - 300;
    ly = longint'($urandom_range(0, 600)) - 300;
    if ($urandom_range(0, 7) == 0) ly = $urandom_range(0, 1) ? lx : -lx;
    send_item(OP_LOAD, 17'(bx), 17'(by), 17'(bx + lx), 17'(by + ly));
    cap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : 80;
    n = 0;
    while (ln_phase != LnIdle && n < cap) begin
      send_step();
      n++;
    end
    repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : 0) send_step();
  endtask

  task automatic directed_items();
    // Culled on each of the four window edges, each followed by a step that finds no line.
    send_item(OP_LOAD, -17'sd16, 17'sd100, -17'sd1, 17'sd200);
    send_step();
    send_item(OP_LOAD, 17'sd20000, 17'sd100, 17'sd12801, 17'sd200);
    send_step();
    send_item(OP_LOAD, 17'sd100, -17'sd5, 17'sd300, 17'h10000);
    send_step();
    send_item(OP_LOAD, 17'sd100, 17'sd65535, 17'sd300, 17'sd9601);
    send_step();
    // Zero length: both ends are the same pixel.
    send_item(OP_LOAD, 17'sd37, 17'sd53, 17'sd37, 17'sd53);
    repeat (3) send_step();
    // Steep line given bottom to top, then a shallow one right to left.
    send_item(OP_LOAD, 17'sd200, 17'sd400, 17'sd180, 17'sd250);
    repeat (4) send_step();
    send_item(OP_LOAD, 17'sd300, 17'sd40, 17'sd199, 17'sd90);
    // A load that replaces a line in progress.
    send_item(OP_LOAD, 17'sd8, 17'sd8, 17'sd64, 17'sd64);
    repeat (6) send_step();
    // Full-range ends: a very long line, cut off after a few columns.
    send_item(OP_LOAD, 17'h10000, 17'h10000, 17'sd65535, 17'sd65535);
    repeat (4) send_step();
  endtask

  initial begin
    logic [11:0] ws[6];
    logic [11:0] hs[6];
    logic [7:0]  as[6];
    int k;
    sb = new();
    allow_gaps = 1'b1;
    sent = 0;
    rst_ni <= 1'b0;
    start_i <= 1'b0; opcode_i <= OP_LOAD;
    start_x_i <= '0; start_y_i <= '0; end_x_i <= '0; end_y_i <= '0;
    cfg_we_i <= 1'b0; cfg_idx_i <= CFG_WIDTH; cfg_data_i <= '0;
    win_w = 800; win_h = 600; draw_a = 255;
    ln_phase = LnIdle; ln_steep = 1'b0;
    ln_col = 0; ln_end_col = 0; ln_icpt = 0; ln_slope = 0;
    row_first = 0; row_second = 0; alphas_first = '0; alphas_second = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values first, then the extremes, then random windows and alphas.
    ws = '{800, 1, 4095, 12'hFFF, 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095))};
    hs = '{600, 1, 4095, 1, 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095))};
    as = '{255, 0, 255, 1, 8'($urandom), 8'($urandom)};
    directed_items();
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_config(ws[ph], hs[ph], as[ph]);
      allow_gaps = (ph < 5);
      // Each window setting gets about 300 items.
      k = sent + 300;
      while (sent < k) begin
        if ($urandom_range(0, 9) < 8) begin
          draw_random_line();
        end else begin
          // Noise: any opcode with coordinates over the whole range.
          send_item(1'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                    17'($urandom));
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_pairs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
